// ----- rtl/skvt_pkg.sv -----
// Shared types, codes and default sizes of the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_GET    = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Broadcast command seen by every cell
    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_REPLACE = 2'd2,
        CELL_REMOVE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic gt;   // occupied and stored key above the request key
        logic hit;  // occupied and stored key equal to the request key
    } t_cell_flags;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [4:0]  entry_count;
    } t_rsp;

endpackage
`default_nettype wire

// ----- rtl/skvt_cell.sv -----
// One slot of the table: a key/value register with its compare and shift logic.
`timescale 1ns / 1ps
`default_nettype none
module skvt_cell
    import skvt_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire t_cell_op              i_op,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_occ,
    input  wire logic                  i_left_gt,
    input  wire logic [KEY_BITS-1:0]   i_left_key,
    input  wire logic [VALUE_BITS-1:0] i_left_value,
    input  wire logic [KEY_BITS-1:0]   i_right_key,
    input  wire logic [VALUE_BITS-1:0] i_right_value,
    output t_cell_flags                o_flags,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [VALUE_BITS-1:0]      o_value
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [KEY_BITS-1:0]   n_key;
    logic [VALUE_BITS-1:0] n_value;

    assign o_flags.gt  = i_occ && (r_key > i_key);
    assign o_flags.hit = i_occ && (r_key == i_key);
    assign o_key       = r_key;
    assign o_value     = r_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        case (i_op)
            CELL_INSERT: begin
                // the slot where the left neighbour is the last greater key takes the new pair
                if (i_left_gt && !o_flags.gt) begin
                    n_key   = i_key;
                    n_value = i_value;
                end else if (!i_left_gt) begin
                    n_key   = i_left_key;
                    n_value = i_left_value;
                end
            end
            CELL_REPLACE: begin
                if (o_flags.hit) begin
                    n_value = i_value;
                end
            end
            CELL_REMOVE: begin
                // close the gap from the hit slot onwards
                if (!o_flags.gt) begin
                    n_key   = i_right_key;
                    n_value = i_right_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule
`default_nettype wire

// ----- rtl/sorted_key_value_table_core.sv -----
// Top level of the sorted key/value table: a row of slot cells and the request control.
`timescale 1ns / 1ps
`default_nettype none
// The table keeps up to DEPTH key/value pairs in descending unsigned key order,
// one pair per cell of a linear row. A request (insert or replace, remove, get,
// clear) is taken on every clock edge at which start is high; busy is always low,
// so a new request may follow in each cycle. All cells compare the request key
// against their stored key in parallel, and an insert or remove shifts the row by
// one slot towards its right or left neighbour within the same cycle. The result
// of each request is registered and appears on o_rsp in the cycle after its transfer,
// marked by o_done for that one cycle; the receiver cannot stall it, so it must
// take it then. Throughput is one request per cycle, set by the single
// compare-and-shift step of the cell row. A get or remove that misses
// returns not-found; an insert of a new key into a full table returns full and
// changes nothing. After reset the table is empty; cell contents need no clearing.
module sorted_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_done;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;

    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    t_cell_op              cell_op;
    t_cell_flags           flags [DEPTH];
    logic [KEY_BITS-1:0]   cell_key [DEPTH];
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]      hit_vec;
    logic                  any_hit;
    logic                  full;
    logic [VALUE_BITS-1:0] hit_value;

    // Keep only the low KEY_BITS / VALUE_BITS of the request fields
    assign req_key   = KEY_BITS'(i_req.key);
    assign req_value = VALUE_BITS'(i_req.value_in);
    assign busy      = 1'b0;
    assign full      = (r_count == CW'(DEPTH));

    // Row of cells: cell 0 holds the largest key
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  left_gt;
        logic [KEY_BITS-1:0]   left_key;
        logic [VALUE_BITS-1:0] left_value;
        logic [KEY_BITS-1:0]   right_key;
        logic [VALUE_BITS-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_gt    = 1'b1;
            assign left_key   = cell_key[g];
            assign left_value = cell_value[g];
        end else begin : g_inner_left
            assign left_gt    = flags[g-1].gt;
            assign left_key   = cell_key[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_key   = cell_key[g];
            assign right_value = cell_value[g];
        end else begin : g_inner_right
            assign right_key   = cell_key[g+1];
            assign right_value = cell_value[g+1];
        end

        skvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (cell_op),
            .i_key         (req_key),
            .i_value       (req_value),
            .i_occ         (CW'(g) < r_count),
            .i_left_gt     (left_gt),
            .i_left_key    (left_key),
            .i_left_value  (left_value),
            .i_right_key   (right_key),
            .i_right_value (right_value),
            .o_flags       (flags[g]),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g])
        );

        assign hit_vec[g] = flags[g].hit;
    end

    assign any_hit = |hit_vec;

    // At most one cell hits, since keys are unique: OR the masked values together
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_value = hit_value | (hit_vec[i] ? cell_value[i] : '0);
        end
    end

    // Decode the transfer into the cell command, the new count and the result
    always_comb begin
        cell_op           = CELL_HOLD;
        n_count           = r_count;
        n_rsp.status      = ST_OK;
        n_rsp.value_out   = '0;
        if (start) begin
            case (t_action'(i_req.action))
                ACT_INSERT: begin
                    if (any_hit) begin
                        cell_op = CELL_REPLACE;
                    end else if (full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        cell_op = CELL_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (any_hit) begin
                        cell_op         = CELL_REMOVE;
                        n_count         = r_count - 1'b1;
                        n_rsp.value_out = 32'(hit_value);
                    end else begin
                        n_rsp.status = ST_MISSING;
                    end
                end
                ACT_GET: begin
                    if (any_hit) begin
                        n_rsp.value_out = 32'(hit_value);
                    end else begin
                        n_rsp.status = ST_MISSING;
                    end
                end
                ACT_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
        n_rsp.entry_count = 5'(n_count);
    end

    // Advance the count and strobe; register the result payload without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= start;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

// ----- rtl/skvt_checker.sv -----
// Port-level checks of the sorted key/value table, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module skvt_port_checks
    import skvt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire t_req i_req,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    // Each transfer yields one result in the next cycle, and nothing else does
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("result strobe missing after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result strobe without transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.entry_count <= 5'(DEPTH)))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_FULL) |->
            (o_rsp.entry_count == 5'(DEPTH) && o_rsp.value_out == '0))
        else $error("full status on a table that is not full");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.action == ACT_CLEAR) |=>
            (o_rsp.entry_count == '0 && o_rsp.status == ST_OK))
        else $error("clear did not empty the table");

endmodule

bind sorted_key_value_table_core skvt_port_checks #(
    .DEPTH (DEPTH)
) u_skvt_port_checks (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire
